/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL of the encoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a trigger implies a consequence in the next cycle, outside reset.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) else $error(msg);

`endif

/* rtl/core/b64enc_pkg.sv */
// Types, character codes and the alphabet lookup for the Base64 encoder core.
`timescale 1ns / 1ps

package b64enc_pkg;

    typedef logic [6:0] t_char;
    typedef logic [5:0] t_code;

    localparam int unsigned MAX_CHARS = 5;
    localparam int unsigned CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int unsigned IDX_W     = $clog2(MAX_CHARS);

    localparam logic [6:0] LINE_CHARS = 7'd72;
    localparam t_char      CHAR_PAD   = 7'h3D;
    localparam t_char      CHAR_NL    = 7'h0A;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic REG_PAD_AND_WRAP = 1'b0;
    localparam logic REG_URL_ALPHABET = 1'b1;

    // Map a 6-bit code to its ASCII character.
    function automatic t_char code_char(input t_code code, input logic url);
        t_char ch;
        begin
            if (code < 6'd26) begin
                ch = 7'h41 + {1'b0, code};
            end else if (code < 6'd52) begin
                ch = 7'h61 + {1'b0, code - 6'd26};
            end else if (code < 6'd62) begin
                ch = 7'h30 + {1'b0, code - 6'd52};
            end else if (code == 6'd62) begin
                ch = url ? 7'h2D : 7'h2B;
            end else begin
                ch = url ? 7'h5F : 7'h2F;
            end
            return ch;
        end
    endfunction

endpackage

/* rtl/core/base64_stream_encoder_core.sv */
// Streaming Base64 encoder: one input word per byte or end mark, one output word per character.
// Each accepted input word is encoded in the cycle it is taken and its characters (zero to
// five) go into a five-entry character register that drains one character per cycle while
// m_axis_tready is high. A byte that is only held gives no character; a byte that completes a
// group gives four characters, or five with a line feed, and the next input word is taken in
// the cycle the last of them leaves. tuser = 1 marks end of message: the partial group is
// flushed, with '=' padding and a final line feed for a non-empty line when padding is on.
// tlast flags the last character caused by one input word.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module base64_stream_encoder_core
    import b64enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_addr,
    input  logic       i_cfg_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] kind
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic       m_axis_tlast    // last_of_run
);

    logic             r_pad;
    logic             r_url;
    logic [7:0]       r_held0;
    logic [7:0]       r_held1;
    logic [1:0]       r_fill;
    logic [6:0]       r_line;
    t_char            r_buf [MAX_CHARS];
    logic [CNT_W-1:0] r_cnt;

    logic [7:0]       n_held0;
    logic [7:0]       n_held1;
    logic [1:0]       n_fill;
    logic [6:0]       n_line;
    t_char            n_load [MAX_CHARS];
    logic [CNT_W-1:0] n_num;

    logic       w_in_acc;
    logic       w_out_acc;
    logic [7:0] w_b;
    logic [7:0] w_c;
    t_code      w_s0, w_s1, w_s2, w_s3;
    logic [6:0] w_line4;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    // Take a new word when the character register is empty or loses its last entry now.
    assign s_axis_tready = (r_cnt == '0) ||
                           (r_cnt == CNT_W'(1) && m_axis_tready);
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = {1'b0, r_buf[0]};
    assign m_axis_tlast  = (r_cnt == CNT_W'(1));

    // Sextets of the group; a flush fills the missing bytes with zeros.
    assign w_b = (s_axis_tuser == KIND_END && r_fill == 2'd1) ? 8'h00 : r_held1;
    assign w_c = (s_axis_tuser == KIND_END) ? 8'h00 : s_axis_tdata;
    assign w_s0 = r_held0[7:2];
    assign w_s1 = {r_held0[1:0], w_b[7:4]};
    assign w_s2 = {w_b[3:0], w_c[7:6]};
    assign w_s3 = w_c[5:0];
    assign w_line4 = r_line + 7'd4;

    always_comb begin
        logic [IDX_W-1:0] v_n;
        v_n     = '0;
        n_held0 = r_held0;
        n_held1 = r_held1;
        n_fill  = r_fill;
        n_line  = r_line;
        n_num   = '0;
        for (int i = 0; i < MAX_CHARS; i++) begin
            n_load[i] = CHAR_NL;
        end
        if (s_axis_tuser == KIND_DATA) begin
            if (r_fill < 2'd2) begin
                if (r_fill[0] == 1'b0) begin
                    n_held0 = s_axis_tdata;
                end else begin
                    n_held1 = s_axis_tdata;
                end
                n_fill = r_fill + 2'd1;
            end else begin
                n_load[0] = code_char(w_s0, r_url);
                n_load[1] = code_char(w_s1, r_url);
                n_load[2] = code_char(w_s2, r_url);
                n_load[3] = code_char(w_s3, r_url);
                n_num     = CNT_W'(4);
                n_fill    = 2'd0;
                if (w_line4 >= LINE_CHARS) begin
                    n_line = 7'd0;
                    if (r_pad) begin
                        n_load[4] = CHAR_NL;
                        n_num     = CNT_W'(5);
                    end
                end else begin
                    n_line = w_line4;
                end
            end
        end else begin
            if (r_fill != 2'd0) begin
                n_load[v_n] = code_char(w_s0, r_url);
                v_n = v_n + 1'b1;
                n_load[v_n] = code_char(w_s1, r_url);
                v_n = v_n + 1'b1;
                if (r_fill == 2'd1) begin
                    if (r_pad) begin
                        n_load[v_n] = CHAR_PAD;
                        v_n = v_n + 1'b1;
                    end
                end else begin
                    n_load[v_n] = code_char(w_s2, r_url);
                    v_n = v_n + 1'b1;
                end
                if (r_pad) begin
                    n_load[v_n] = CHAR_PAD;
                    v_n = v_n + 1'b1;
                end
            end
            n_num = CNT_W'(v_n);
            // Close a non-empty line.
            if (r_pad && (r_fill != 2'd0 || r_line != 7'd0)) begin
                n_load[v_n] = CHAR_NL;
                n_num = CNT_W'(v_n) + CNT_W'(1);
            end
            n_fill = 2'd0;
            n_line = 7'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad   <= 1'b1;
            r_url   <= 1'b0;
            r_held0 <= 8'h00;
            r_held1 <= 8'h00;
            r_fill  <= 2'd0;
            r_line  <= 7'd0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_PAD_AND_WRAP: r_pad <= i_cfg_wdata;
                    REG_URL_ALPHABET: r_url <= i_cfg_wdata;
                    default:          r_pad <= r_pad;
                endcase
            end
            if (w_in_acc) begin
                r_held0 <= n_held0;
                r_held1 <= n_held1;
                r_fill  <= n_fill;
                r_line  <= n_line;
                r_cnt   <= n_num;
            end else if (w_out_acc) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Load new characters on accept, else advance the queue as words leave.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int i = 0; i < MAX_CHARS; i++) begin
                r_buf[i] <= n_load[i];
            end
        end else if (w_out_acc) begin
            for (int i = 0; i < MAX_CHARS - 1; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
        end
    end

    `ASSERT_CLK(a_cnt_range, r_cnt <= CNT_W'(MAX_CHARS), "character count out of range")
    `ASSERT_CLK(a_fill_range, r_fill != 2'd3, "group fill reached three")
    `ASSERT_CLK(a_line_step, r_line[1:0] == 2'b00 && r_line < LINE_CHARS, "line count off step")
    `ASSERT_NEXT(a_group_emit, w_in_acc && s_axis_tuser == KIND_DATA && r_fill == 2'd2, r_cnt == CNT_W'(4) || r_cnt == CNT_W'(5), "full group did not queue four characters")
    `ASSERT_NEXT(a_end_clear, w_in_acc && s_axis_tuser == KIND_END, r_fill == 2'd0 && r_line == 7'd0, "end of message left state behind")

endmodule
